/* sv/esckd_pkg.sv */
// ----------------------------------------------------------------------------
// esckd_pkg
// Shared types and constants for the arrow-key escape sequence decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esckd_pkg;

    localparam int unsigned DEFAULT_MAX_SEQ_LEN = 8;
    localparam int unsigned NUM_CFG             = 4;
    localparam int unsigned NUM_FIXED           = 8;
    localparam int unsigned ENTRY_BYTES         = 7;
    localparam int unsigned KEY_W               = 9;
    localparam int unsigned CFG_IDX_W           = 2;
    localparam int unsigned CFG_W               = 64;

    localparam logic [7:0] ESC_BYTE  = 8'h1b;
    localparam logic [7:0] FIXED_LEN = 8'd3;
    localparam logic [7:0] MAX_ENTRY_LEN = 8'd7;

    localparam logic [7:0] FIXED_MID  [NUM_FIXED] = '{
        8'h5b, 8'h5b, 8'h5b, 8'h5b, 8'h4f, 8'h4f, 8'h4f, 8'h4f
    };
    localparam logic [7:0] FIXED_LAST [NUM_FIXED] = '{
        8'h44, 8'h43, 8'h41, 8'h42, 8'h44, 8'h43, 8'h41, 8'h42
    };
    localparam logic [KEY_W-1:0] KEY_CODE [NUM_CFG] = '{
        9'h101, 9'h102, 9'h103, 9'h104
    };

    typedef struct packed {
        logic             exact;
        logic             prefix;
        logic [KEY_W-1:0] key;
    } match_t;

endpackage

`default_nettype wire

/* sv/esckd_match.sv */
// ----------------------------------------------------------------------------
// esckd_match
// Compares the candidate buffer against the twelve-entry sequence table.
// ----------------------------------------------------------------------------
`default_nettype none

module esckd_match #(
    parameter int unsigned LEN_W = 4
) (
    input  wire logic [esckd_pkg::CFG_W-1:0] cfg_seq [esckd_pkg::NUM_CFG],
    input  wire logic [7:0]                  cand [esckd_pkg::ENTRY_BYTES],
    input  wire logic [LEN_W-1:0]            new_len,
    output esckd_pkg::match_t                result
);

    localparam int unsigned NUM_ENTRIES = esckd_pkg::NUM_CFG + esckd_pkg::NUM_FIXED;

    logic [7:0]                          len8;
    logic [esckd_pkg::ENTRY_BYTES-1:0]   in_mask;
    logic [NUM_ENTRIES-1:0]              live;
    logic [NUM_ENTRIES-1:0]              exact;

    assign len8 = 8'(new_len);

    always_comb
    begin
        for (int i = 0; i < esckd_pkg::ENTRY_BYTES; i++)
        begin
            in_mask[i] = (8'(i) < len8);
        end
    end

    always_comb
    begin
        logic [esckd_pkg::ENTRY_BYTES-1:0] eq;
        logic [7:0]                        elen;
        logic                              ok;
        for (int k = 0; k < esckd_pkg::NUM_CFG; k++)
        begin
            elen = cfg_seq[k][63:56];
            for (int i = 0; i < esckd_pkg::ENTRY_BYTES; i++)
            begin
                eq[i] = (cand[i] == cfg_seq[k][8*i +: 8]);
            end
            ok = (elen != 8'd0) && (elen <= esckd_pkg::MAX_ENTRY_LEN) &&
                 (len8 <= elen) && (&(eq | ~in_mask));
            live[k]  = ok;
            exact[k] = ok && (len8 == elen);
        end
        for (int k = 0; k < esckd_pkg::NUM_FIXED; k++)
        begin
            eq    = '1;
            eq[0] = (cand[0] == esckd_pkg::ESC_BYTE);
            eq[1] = (cand[1] == esckd_pkg::FIXED_MID[k]);
            eq[2] = (cand[2] == esckd_pkg::FIXED_LAST[k]);
            ok = (len8 <= esckd_pkg::FIXED_LEN) && (&(eq | ~in_mask));
            live[esckd_pkg::NUM_CFG + k]  = ok;
            exact[esckd_pkg::NUM_CFG + k] = ok && (len8 == esckd_pkg::FIXED_LEN);
        end
    end

    always_comb
    begin
        result.exact  = |exact;
        result.prefix = |live;
        result.key    = '0;
        for (int k = NUM_ENTRIES - 1; k >= 0; k--)
        begin
            if (exact[k])
            begin
                result.key = esckd_pkg::KEY_CODE[k % esckd_pkg::NUM_CFG];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/escape_sequence_key_decoder_core.sv */
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder_core
// Output: a key code is registered and is on m_tdata in the cycle after the byte that completes it.
// Throughput: one byte per cycle while s_tready is high; the table compare is a single combinational pass.
// s_tready drops only while a finished key code waits on a stalled m_tready.
// Reset: asynchronous; clears the sequence length (idle), the output valid and
// the four arrow sequence registers (all entries absent).
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_key_decoder_core #(
    parameter int unsigned MAX_SEQ_LEN = esckd_pkg::DEFAULT_MAX_SEQ_LEN
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] raw_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,   // [8:0] key_code
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [esckd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [esckd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int unsigned LEN_W     = $clog2(MAX_SEQ_LEN + 1);
    localparam int unsigned BUF_DEPTH = (MAX_SEQ_LEN < esckd_pkg::ENTRY_BYTES) ?
                                        MAX_SEQ_LEN : esckd_pkg::ENTRY_BYTES;
    localparam int unsigned IDX_W     = $clog2(BUF_DEPTH);

    logic [esckd_pkg::CFG_W-1:0]   cfg_seq_reg [esckd_pkg::NUM_CFG];
    logic [7:0]                    buf_reg [BUF_DEPTH];
    logic [LEN_W-1:0]              len_reg;
    logic [LEN_W-1:0]              len_next;
    logic [LEN_W-1:0]              new_len;
    logic                          out_valid_reg;
    logic [esckd_pkg::KEY_W-1:0]   key_reg;
    logic [7:0]                    cand [esckd_pkg::ENTRY_BYTES];
    logic                          accept;
    logic                          emit;
    logic [esckd_pkg::KEY_W-1:0]   emit_code;
    esckd_pkg::match_t             match;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, key_reg};
    assign new_len   = len_reg + LEN_W'(1);

    for (genvar i = 0; i < esckd_pkg::ENTRY_BYTES; i++)
    begin : g_cand
        if (i < BUF_DEPTH)
        begin : g_buf
            assign cand[i] = (len_reg == LEN_W'(i)) ? s_tdata : buf_reg[i];
        end
        else
        begin : g_none
            assign cand[i] = s_tdata;
        end
    end

    esckd_match #(
        .LEN_W (LEN_W)
    ) u_match (
        .cfg_seq (cfg_seq_reg),
        .cand    (cand),
        .new_len (new_len),
        .result  (match)
    );

    always_comb
    begin
        len_next  = len_reg;
        emit      = 1'b0;
        emit_code = {1'b0, s_tdata};
        if (len_reg == '0)
        begin
            if (s_tdata != esckd_pkg::ESC_BYTE)
            begin
                emit = 1'b1;
            end
            else
            begin
                len_next = LEN_W'(1);
            end
        end
        else if (32'(len_reg) >= MAX_SEQ_LEN)
        begin
            len_next = '0;
        end
        else if (match.exact)
        begin
            emit      = 1'b1;
            emit_code = match.key;
            len_next  = '0;
        end
        else if (!match.prefix || 32'(new_len) >= MAX_SEQ_LEN)
        begin
            len_next = '0;
        end
        else
        begin
            len_next = new_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < esckd_pkg::NUM_CFG; k++)
            begin
                cfg_seq_reg[k] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                len_reg       <= len_next;
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_seq_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            key_reg <= emit_code;
        end
        if (accept && (32'(len_reg) < BUF_DEPTH))
        begin
            buf_reg[len_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

endmodule

`default_nettype wire
